// ===== hw/rtl/sbdfa_pkg.sv =====
// shared types and constants for the serial byte demux and frame assembler
// no dependencies; used by every module of the block by scoped names
package sbdfa_pkg;

    // frame and destination sizing
    localparam int FRAME_LEN  = 5;
    localparam int DEST_LIMIT = 6;
    localparam int CNT_W      = $clog2(FRAME_LEN);
    localparam int ACC_W      = (FRAME_LEN - 1) * 8;
    localparam int WORD_W     = 40;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;

    // destination codes
    localparam logic [2:0] DEST_NONE  = 3'd0;
    localparam logic [2:0] DEST_FRAME = 3'd1;
    localparam logic [2:0] DEST_PORT2 = 3'd2;

    // command queue sizing
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PORT2 = 2'd0,
        KIND_SOFT  = 2'd1,
        KIND_FRAME = 2'd2
    } t_kind;

    // one data byte together with the destination it was addressed to
    typedef struct packed {
        logic [2:0] dest;
        logic [7:0] data;
    } t_cmd;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

// ===== hw/rtl/sbdfa_front.sv =====
// front end: holds the destination byte and turns each data byte into a command
// depends on sbdfa_pkg
module sbdfa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_rx_byte,
    input  sbdfa_pkg::t_q_status i_q_status,
    output logic              o_cmd_push,
    output sbdfa_pkg::t_cmd   o_cmd
);

    logic [2:0] r_held;
    logic [2:0] n_held;
    logic       w_accept;

    assign w_accept = i_push && !i_q_status.full;

    always_comb begin
        n_held     = r_held;
        o_cmd_push = 1'b0;
        o_cmd.dest = r_held;
        o_cmd.data = i_rx_byte;
        if (w_accept) begin
            if (r_held == sbdfa_pkg::DEST_NONE) begin
                // a bad destination byte is simply dropped
                if ((i_rx_byte != 8'd0) && (i_rx_byte < 8'(sbdfa_pkg::DEST_LIMIT))) begin
                    n_held = i_rx_byte[2:0];
                end
            end else begin
                o_cmd_push = 1'b1;
                n_held     = sbdfa_pkg::DEST_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= sbdfa_pkg::DEST_NONE;
        end else begin
            r_held <= n_held;
        end
    end

endmodule

// ===== hw/rtl/sbdfa_cmd_fifo.sv =====
// short command queue between front and back end
// depends on sbdfa_pkg
module sbdfa_cmd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sbdfa_pkg::t_cmd      i_cmd,
    input  logic                 i_pop,
    output sbdfa_pkg::t_cmd      o_cmd,
    output sbdfa_pkg::t_q_status o_status
);

    sbdfa_pkg::t_cmd                r_mem [sbdfa_pkg::Q_DEPTH];
    logic [sbdfa_pkg::Q_AW-1:0]     r_wr_ptr;
    logic [sbdfa_pkg::Q_AW-1:0]     r_rd_ptr;
    logic [sbdfa_pkg::Q_CW-1:0]     r_count;
    logic                           w_wr;
    logic                           w_rd;

    assign o_status.full  = (r_count == sbdfa_pkg::Q_CW'(sbdfa_pkg::Q_DEPTH));
    assign o_status.valid = (r_count != '0);
    assign w_wr  = i_push && !o_status.full;
    assign w_rd  = i_pop && o_status.valid;
    assign o_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sbdfa_back.sv =====
// back end: carries out commands, assembles frames and holds the result register
// depends on sbdfa_pkg
module sbdfa_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sbdfa_pkg::t_q_status         i_q_status,
    input  sbdfa_pkg::t_cmd              i_cmd,
    output logic                         o_cmd_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [1:0]                   o_dest_kind,
    output logic [2:0]                   o_dest_id,
    output logic [7:0]                   o_data_byte,
    output logic [sbdfa_pkg::WORD_W-1:0] o_frame_word
);

    localparam int EXT_W = sbdfa_pkg::ACC_W + 8 + sbdfa_pkg::WORD_W;

    logic [sbdfa_pkg::CNT_W-1:0]   r_count;
    logic [sbdfa_pkg::CNT_W-1:0]   n_count;
    logic [sbdfa_pkg::ACC_W-1:0]   r_acc;
    logic [sbdfa_pkg::ACC_W-1:0]   n_acc;
    logic                          r_out_valid;
    logic                          n_out_valid;
    sbdfa_pkg::t_kind              r_kind;
    sbdfa_pkg::t_kind              n_kind;
    logic [2:0]                    r_id;
    logic [2:0]                    n_id;
    logic [7:0]                    r_data;
    logic [7:0]                    n_data;
    logic [sbdfa_pkg::WORD_W-1:0]  r_word;
    logic [sbdfa_pkg::WORD_W-1:0]  n_word;
    logic [EXT_W-1:0]              w_ext;
    logic                          w_result;

    // slot free, or being emptied this cycle
    assign o_cmd_pop = i_q_status.valid && (!r_out_valid || i_pop);
    assign w_ext     = {{sbdfa_pkg::WORD_W{1'b0}}, r_acc, i_cmd.data};

    always_comb begin
        n_count  = r_count;
        n_acc    = r_acc;
        n_kind   = r_kind;
        n_id     = r_id;
        n_data   = r_data;
        n_word   = r_word;
        w_result = 1'b0;
        if (o_cmd_pop) begin
            priority if (i_cmd.dest == sbdfa_pkg::DEST_FRAME) begin
                if (r_count == '0) begin
                    if (i_cmd.data == sbdfa_pkg::HEADER_BYTE) begin
                        n_acc   = {r_acc[sbdfa_pkg::ACC_W-9:0], i_cmd.data};
                        n_count = sbdfa_pkg::CNT_W'(1);
                    end
                end else if (r_count == sbdfa_pkg::CNT_W'(sbdfa_pkg::FRAME_LEN - 1)) begin
                    w_result = 1'b1;
                    n_kind   = sbdfa_pkg::KIND_FRAME;
                    n_id     = sbdfa_pkg::DEST_FRAME;
                    n_data   = 8'd0;
                    n_word   = w_ext[sbdfa_pkg::WORD_W-1:0];
                    n_count  = '0;
                end else begin
                    n_acc   = {r_acc[sbdfa_pkg::ACC_W-9:0], i_cmd.data};
                    n_count = r_count + 1'b1;
                end
            end else if (i_cmd.dest == sbdfa_pkg::DEST_PORT2) begin
                w_result = 1'b1;
                n_kind   = sbdfa_pkg::KIND_PORT2;
                n_id     = i_cmd.dest;
                n_data   = i_cmd.data;
                n_word   = '0;
            end else begin
                w_result = 1'b1;
                n_kind   = sbdfa_pkg::KIND_SOFT;
                n_id     = i_cmd.dest;
                n_data   = i_cmd.data;
                n_word   = '0;
            end
        end
        n_out_valid = w_result || (r_out_valid && !i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_kind <= n_kind;
        r_id   <= n_id;
        r_data <= n_data;
        r_word <= n_word;
    end

    assign o_empty      = !r_out_valid;
    assign o_dest_kind  = r_kind;
    assign o_dest_id    = r_id;
    assign o_data_byte  = r_data;
    assign o_frame_word = r_word;

endmodule

// ===== hw/rtl/serial_byte_demux_frame_assembler.sv =====
// top level of the serial byte demux and frame assembler
// depends on sbdfa_pkg, sbdfa_front, sbdfa_cmd_fifo and sbdfa_back
//
// usage
//   input channel: drive i_rx_byte and raise i_push; a byte is taken at a rising
//   edge where i_push is high and o_full is low. bytes come in pairs, a
//   destination byte then a data byte
//   result channel: while o_empty is low the oldest result sits on o_dest_kind,
//   o_dest_id, o_data_byte and o_frame_word; it is taken at an edge where
//   i_pop is high and o_empty is low
//   result path: a taken data byte enters the command queue and the back end
//   then executes it into the result register, given an empty queue and a free
//   result register
//   throughput: one byte per cycle while results are popped; the back end runs
//   one queued command per cycle while its result register is free or popped
//   reset: synchronous, active low; no destination held, no frame open, queue
//   and result register empty; no clearing pass is needed
//   receiver stall: the result register holds, the back end stops taking
//   commands, the four-entry command queue fills and o_full then stops input
module serial_byte_demux_frame_assembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_dest_kind,
    output logic [2:0]  o_dest_id,
    output logic [7:0]  o_data_byte,
    output logic [39:0] o_frame_word
);

    // front to queue
    logic                 w_cmd_push;
    sbdfa_pkg::t_cmd      w_cmd_in;
    // queue to back
    sbdfa_pkg::t_cmd      w_cmd_out;
    logic                 w_cmd_pop;
    sbdfa_pkg::t_q_status w_q_status;

    // destination tracking and classification of each byte
    sbdfa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_rx_byte  (i_rx_byte),
        .i_q_status (w_q_status),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    // decoupling queue of data bytes with their destination
    sbdfa_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_cmd_push),
        .i_cmd    (w_cmd_in),
        .i_pop    (w_cmd_pop),
        .o_cmd    (w_cmd_out),
        .o_status (w_q_status)
    );

    // forwarding, frame assembly and result register
    sbdfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (w_q_status),
        .i_cmd        (w_cmd_out),
        .o_cmd_pop    (w_cmd_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_dest_kind  (o_dest_kind),
        .o_dest_id    (o_dest_id),
        .o_data_byte  (o_data_byte),
        .o_frame_word (o_frame_word)
    );

    // input is refused only when the command queue is full
    assign o_full = w_q_status.full;

    // the front never pushes a command into a full queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_q_status.full)
        else $error("command pushed into full queue");

    // an unpopped result stays in the result register
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> !o_empty)
        else $error("waiting result lost");

    // a completed frame always carries destination one and no data byte
    a_frame_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_dest_kind == sbdfa_pkg::KIND_FRAME)) |->
        ((o_dest_id == sbdfa_pkg::DEST_FRAME) && (o_data_byte == 8'd0)))
        else $error("frame result with wrong id or data");

    // soft port results carry an id in the soft range
    a_soft_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_dest_kind == sbdfa_pkg::KIND_SOFT)) |->
        ((o_dest_id > sbdfa_pkg::DEST_PORT2) &&
         (o_dest_id < 3'(sbdfa_pkg::DEST_LIMIT)) && (o_frame_word == '0)))
        else $error("soft port result with bad id");

endmodule

// ===== tb/sbdfa_route_tracker_pkg.sv =====
// expected-result tracker for the serial byte demux and frame assembler testbench
// depends on sbdfa_pkg for sizes, destination codes and the result kind enum
package sbdfa_route_tracker_pkg;

    import sbdfa_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  id;
        logic [7:0]  data;
        logic [39:0] word;
    } t_route;

    class route_tracker;

        t_route      pending_routes[$];
        logic [2:0]  held_dest = DEST_NONE;
        int unsigned frame_fill = 0;
        logic [7:0]  frame_bytes [FRAME_LEN-1];
        int unsigned bytes_taken = 0;
        int unsigned bytes_used = 0;
        int unsigned errors = 0;
        int unsigned kind_count [3] = '{0, 0, 0};

        // one accepted byte: update the copy of the state, queue any result
        function void take_byte(logic [7:0] b);
            t_route     r;
            logic [63:0] acc;
            logic [2:0] d;
            int         i;
            d = held_dest;
            bytes_taken++;
            if (d == DEST_NONE) begin
                // bad destination bytes leave nothing behind
                if (b > 0 && b < DEST_LIMIT) begin
                    held_dest = b[2:0];
                    bytes_used++;
                end
                return;
            end
            bytes_used++;
            held_dest = DEST_NONE;
            if (d == DEST_FRAME) begin
                if (frame_fill == 0) begin
                    if (b == HEADER_BYTE) begin
                        frame_bytes[0] = b;
                        frame_fill = 1;
                    end
                    return;
                end
                if (frame_fill >= FRAME_LEN - 1) begin
                    acc = '0;
                    for (i = 0; i < FRAME_LEN - 1; i++)
                        acc = {acc[55:0], frame_bytes[i]};
                    acc = {acc[55:0], b};
                    frame_fill = 0;
                    r.kind = KIND_FRAME;
                    r.id   = DEST_FRAME;
                    r.data = '0;
                    r.word = acc[39:0];
                    pending_routes.push_back(r);
                    return;
                end
                frame_bytes[frame_fill] = b;
                frame_fill++;
                return;
            end
            r.kind = (d == DEST_PORT2) ? KIND_PORT2 : KIND_SOFT;
            r.id   = d;
            r.data = b;
            r.word = '0;
            pending_routes.push_back(r);
        endfunction

        // one accepted result against the oldest expectation
        function void check_route(logic [1:0] kind, logic [2:0] id, logic [7:0] data,
                                  logic [39:0] word);
            t_route e;
            if (pending_routes.size() == 0) begin
                $display("%0t: unexpected result kind %0h id %0h data %0h word %0h",
                         $time, kind, id, data, word);
                errors++;
                return;
            end
            e = pending_routes.pop_front();
            if (kind != e.kind) begin
                $display("%0t: dest_kind expected %0h actual %0h", $time, e.kind, kind);
                errors++;
            end
            if (id != e.id) begin
                $display("%0t: dest_id expected %0h actual %0h", $time, e.id, id);
                errors++;
            end
            if (data != e.data) begin
                $display("%0t: data_byte expected %0h actual %0h", $time, e.data, data);
                errors++;
            end
            if (word != e.word) begin
                $display("%0t: frame_word expected %0h actual %0h", $time, e.word, word);
                errors++;
            end
            if (e.kind <= KIND_FRAME)
                kind_count[e.kind]++;
        endfunction

    endclass

endpackage

// ===== tb/serial_byte_demux_frame_assembler_test.sv =====
// self-checking testbench for serial_byte_demux_frame_assembler
// depends on sbdfa_pkg, sbdfa_route_tracker_pkg and the block's rtl
module serial_byte_demux_frame_assembler_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sbdfa_pkg::*;
    import sbdfa_route_tracker_pkg::*;

    // cycles with no transfer on either side before the run is abandoned
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 1850;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [7:0]  i_rx_byte;
    logic        i_pop;
    logic        o_empty;
    logic [1:0]  o_dest_kind;
    logic [2:0]  o_dest_id;
    logic [7:0]  o_data_byte;
    logic [39:0] o_frame_word;

    route_tracker tracker = new();

    // when set, neither side idles
    bit steady = 1'b0;
    int unsigned quiet_cycles = 0;

    serial_byte_demux_frame_assembler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_rx_byte    (i_rx_byte),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_dest_kind  (o_dest_kind),
        .o_dest_id    (o_dest_id),
        .o_data_byte  (o_data_byte),
        .o_frame_word (o_frame_word)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: raises i_pop with a chance of about two in three, always while steady
    always @(negedge i_clk) begin
        if (steady)
            i_pop <= 1'b1;
        else
            i_pop <= ($urandom_range(99) >= 34);
    end

    // monitor: inputs are noted before results are checked, which is safe since
    // no result can come out in the cycle of the byte that causes it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (i_push && !o_full)
                tracker.take_byte(i_rx_byte);
            if (i_pop && !o_empty)
                tracker.check_route(o_dest_kind, o_dest_id, o_data_byte, o_frame_word);
            if ((i_push && !o_full) || (i_pop && !o_empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            // watchdog
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, tracker.pending_routes.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // one byte transfer, with random idle cycles in front of it
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 34) begin
            @(negedge i_clk);
            i_push    <= 1'b0;
            i_rx_byte <= 8'($urandom_range(255));
        end
        @(negedge i_clk);
        i_push    <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
    endtask

    // destination byte followed by its data byte
    task automatic send_pair(input logic [7:0] dest, input logic [7:0] data);
        send_byte(dest);
        send_byte(data);
    endtask

    // sender holds off until every expected result has been popped
    task automatic drain_results();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (tracker.pending_routes.size() != 0)
            @(negedge i_clk);
    endtask

    // payload byte, leaning towards the extremes now and then
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // header plus the rest of a frame, sometimes interleaved with other
    // destinations and sometimes cut short so a later frame finishes it
    task automatic send_frame();
        int k;
        send_pair(8'(DEST_FRAME), HEADER_BYTE);
        for (k = 1; k < FRAME_LEN; k++) begin
            if ($urandom_range(99) < 10)
                return;
            if ($urandom_range(99) < 20)
                send_pair(8'($urandom_range(DEST_PORT2, DEST_LIMIT - 1)), pick_payload());
            send_pair(8'(DEST_FRAME), pick_payload());
        end
    endtask

    initial begin
        int unsigned start_used;
        int unsigned sel;
        int          n;

        i_clk     = 1'b0;
        i_rst_n   = 1'b0;
        i_push    = 1'b0;
        i_rx_byte = 8'h00;
        i_pop     = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bad destination bytes (zero, just past the limit, all ones)
        send_byte(8'h00);
        send_byte(8'(DEST_LIMIT));
        send_byte(8'hFF);
        // second port with both payload extremes
        send_pair(8'(DEST_PORT2), 8'h00);
        send_pair(8'(DEST_PORT2), 8'hFF);
        // every soft port id
        for (n = 3; n < DEST_LIMIT; n++)
            send_pair(8'(n), 8'(8'hA5 ^ n));
        // non-header byte at frame start is dropped
        send_pair(8'(DEST_FRAME), 8'h7F);
        // full frame with a soft port transfer in the middle of it
        send_pair(8'(DEST_FRAME), HEADER_BYTE);
        send_pair(8'(DEST_FRAME), 8'h00);
        send_pair(8'd3, 8'h12);
        send_pair(8'(DEST_FRAME), 8'h80);
        for (n = 3; n < FRAME_LEN; n++)
            send_pair(8'(DEST_FRAME), 8'(8'h01 << n));
        drain_results();

        // random: mostly well-formed pairs and frames, some stray bytes
        start_used = tracker.bytes_used;
        while (tracker.bytes_used - start_used < RANDOM_BYTES) begin
            steady = (tracker.bytes_used - start_used >= 700) &&
                     (tracker.bytes_used - start_used < 1000);
            sel = $urandom_range(99);
            if (sel < 45)
                send_frame();
            else if (sel < 80)
                send_pair(8'($urandom_range(DEST_PORT2, DEST_LIMIT - 1)), pick_payload());
            else if (sel < 88)
                send_pair(8'(DEST_FRAME), pick_payload());
            else
                send_byte(8'($urandom_range(255)));
            if ($urandom_range(199) == 0)
                drain_results();
        end
        steady = 1'b0;

        // wind down: stop sending, wait for the last results, then check that none is left
        drain_results();
        repeat (8) @(posedge i_clk);
        if (tracker.pending_routes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, tracker.pending_routes.size());
            tracker.errors++;
        end

        $display("sent %0d bytes, %0d of them acted on by the demux", tracker.bytes_taken,
                 tracker.bytes_used);
        $display("checked %0d second-port, %0d soft-port and %0d frame transfers",
                 tracker.kind_count[KIND_PORT2], tracker.kind_count[KIND_SOFT],
                 tracker.kind_count[KIND_FRAME]);
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sbdfa_pkg.sv
hw/rtl/sbdfa_front.sv
hw/rtl/sbdfa_cmd_fifo.sv
hw/rtl/sbdfa_back.sv
hw/rtl/serial_byte_demux_frame_assembler.sv
tb/sbdfa_route_tracker_pkg.sv
tb/serial_byte_demux_frame_assembler_test.sv
